@@ hw/rtl/bto_pkg.sv @@
// Shared types and constants for the bitmap text overlay.
// Holds operation codes, register indexes, field widths and the
// controller/datapath command and status structs. No dependencies.
package bto_pkg;

	localparam int COORD_W    = 16;
	localparam int PIX_W      = 11;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int FETCH_W    = 4;
	localparam int STORE_ROWS = 8;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ORIGIN = 2'd1;
	localparam logic [1:0] OP_DRAW   = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNING      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BG_ENABLE    = 3'd6;

	localparam logic [11:0] FRAME_MAX = 12'd2048;

	typedef struct packed {
		logic [8:0]         glyph_count;
		logic signed [4:0]  kerning;
		logic [11:0]        image_width;
		logic [11:0]        image_height;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic               bg_enable;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic origin;
		logic newline;
		logic advance;
		logic start;
		logic fetch;
		logic scan;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_origin;
		logic is_newline;
		logic is_draw;
		logic is_skip;
		logic fetch_done;
		logic scan_done;
		logic flush_done;
		logic hold_valid;
	} sts_t;

endpackage

@@ hw/rtl/bto_ctrl.sv @@
// Controller state machine of the bitmap text overlay.
// Sequences accept, glyph fetch, pixel scan and flush; depends on bto_pkg.
module bto_ctrl import bto_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t st,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = st.is_load;
					cmd.origin  = st.is_origin;
					cmd.newline = st.is_newline;
					cmd.advance = st.is_skip;
					cmd.start   = st.is_draw;
					if (st.is_draw) begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				if (st.fetch_done) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				if (st.flush_done) begin
					cmd.advance = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/bto_dp.sv @@
// Datapath of the bitmap text overlay: glyph memory, row buffer, cursor,
// scan counters, clipping, held pixel and output register. Depends on bto_pkg.
module bto_dp import bto_pkg::*; #(
	parameter int GLYPH_W    = 8,
	parameter int GLYPH_H    = 8,
	parameter int MAX_GLYPHS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  cmd_t                      cmd,
	output sts_t                      st,
	input  logic [1:0]                operation,
	input  logic [7:0]                char_code,
	input  logic [ROW_W-1:0]          glyph_row,
	input  logic [7:0]                row_bits,
	input  logic signed [11:0]        pos_x,
	input  logic signed [11:0]        pos_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [PIX_W-1:0]          pixel_x,
	output logic [PIX_W-1:0]          pixel_y,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic                      is_foreground,
	output logic                      last
);

	localparam int GA_W    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int ADDR_W  = GA_W + ROW_W;
	localparam int DEPTH   = MAX_GLYPHS * STORE_ROWS;

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic [7:0]                glyph_mem [DEPTH];
	logic [7:0]                rd_data_s1;
	logic                      rd_vld_s1;
	logic [ROW_W-1:0]          rd_row_s1;
	logic [7:0]                rows_q [STORE_ROWS];
	logic [7:0]                code_q;
	logic [FETCH_W-1:0]        fcnt_q;
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          rowc_q;
	logic signed [COORD_W-1:0] cur_x_q;
	logic signed [COORD_W-1:0] cur_y_q;
	logic signed [COORD_W-1:0] line_x_q;
	logic                      hold_valid_q;
	logic [PIX_W-1:0]          hold_x_q;
	logic [PIX_W-1:0]          hold_y_q;
	logic                      hold_fg_q;
	logic                      out_valid_q;
	logic [PIX_W-1:0]          out_x_q;
	logic [PIX_W-1:0]          out_y_q;
	logic [COLOR_W-1:0]        out_color_q;
	logic                      out_fg_q;
	logic                      out_last_q;

	logic [8:0]                eff_count;
	logic                      is_text;
	logic [11:0]               wlim;
	logic [11:0]               hlim;
	logic signed [16:0]        px;
	logic signed [16:0]        py;
	logic [7:0]                row_sel;
	logic                      cand_fg;
	logic                      cand_vis;
	logic                      out_free;
	logic                      step_ok;
	logic                      at_end;
	logic                      fetch_rd;
	logic                      push_scan;
	logic                      push_flush;
	logic                      hold_load;
	logic signed [17:0]        adv_sum;
	logic signed [17:0]        nl_sum;

	assign eff_count = (cfg.glyph_count > 9'(MAX_GLYPHS)) ? 9'(MAX_GLYPHS) : cfg.glyph_count;
	assign is_text   = (operation == OP_DRAW) && (char_code != 8'd0) &&
	                   (char_code != NEWLINE_CODE);

	assign st.is_load    = (operation == OP_LOAD);
	assign st.is_origin  = (operation == OP_ORIGIN);
	assign st.is_newline = (operation == OP_DRAW) && (char_code == NEWLINE_CODE);
	assign st.is_draw    = is_text && ({1'b0, char_code} < eff_count);
	assign st.is_skip    = is_text && !({1'b0, char_code} < eff_count);

	assign wlim = (cfg.image_width > FRAME_MAX) ? FRAME_MAX : cfg.image_width;
	assign hlim = (cfg.image_height > FRAME_MAX) ? FRAME_MAX : cfg.image_height;

	assign px       = 17'(cur_x_q) + 17'($signed({1'b0, col_q}));
	assign py       = 17'(cur_y_q) + 17'($signed({1'b0, rowc_q}));
	assign row_sel  = rows_q[rowc_q];
	assign cand_fg  = row_sel[col_q];
	assign cand_vis = !px[16] && !py[16] &&
	                  (px < $signed({5'b0, wlim})) && (py < $signed({5'b0, hlim})) &&
	                  (cand_fg || cfg.bg_enable);

	assign out_free   = !out_valid_q || out_ready;
	assign step_ok    = !cand_vis || !hold_valid_q || out_free;
	assign at_end     = (col_q == COL_W'(GLYPH_W - 1)) && (rowc_q == ROW_W'(GLYPH_H - 1));
	assign push_scan  = cmd.scan && step_ok && cand_vis && hold_valid_q;
	assign push_flush = cmd.flush && hold_valid_q && out_free;
	assign hold_load  = cmd.scan && step_ok && cand_vis;
	assign fetch_rd   = cmd.fetch && (fcnt_q != FETCH_W'(GLYPH_H));

	assign st.fetch_done = (fcnt_q == FETCH_W'(GLYPH_H));
	assign st.scan_done  = cmd.scan && step_ok && at_end;
	assign st.flush_done = !hold_valid_q || out_free;
	assign st.hold_valid = hold_valid_q;

	assign adv_sum = 18'(cur_x_q) + 18'(GLYPH_W) + 18'(cfg.kerning);
	assign nl_sum  = 18'(cur_y_q) + 18'(GLYPH_H);

	always_ff @(posedge clk) begin
		if (cmd.load && ({1'b0, char_code} < 9'(MAX_GLYPHS))) begin
			glyph_mem[{char_code[GA_W-1:0], glyph_row}] <= row_bits;
		end
		if (fetch_rd) begin
			rd_data_s1 <= glyph_mem[{code_q[GA_W-1:0], fcnt_q[ROW_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= fcnt_q[ROW_W-1:0];
		if (rd_vld_s1) begin
			rows_q[rd_row_s1] <= rd_data_s1;
		end
		if (cmd.start) begin
			code_q <= char_code;
		end
		if (hold_load) begin
			hold_x_q  <= px[PIX_W-1:0];
			hold_y_q  <= py[PIX_W-1:0];
			hold_fg_q <= cand_fg;
		end
		if (push_scan || push_flush) begin
			out_x_q     <= hold_x_q;
			out_y_q     <= hold_y_q;
			out_fg_q    <= hold_fg_q;
			out_color_q <= hold_fg_q ? cfg.fg_color : cfg.bg_color;
			out_last_q  <= push_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			fcnt_q       <= '0;
			col_q        <= '0;
			rowc_q       <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			line_x_q     <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= fetch_rd;
			if (cmd.start) begin
				fcnt_q <= '0;
				col_q  <= '0;
				rowc_q <= '0;
			end else begin
				if (fetch_rd) begin
					fcnt_q <= fcnt_q + 1'b1;
				end
				if (cmd.scan && step_ok) begin
					if (rowc_q == ROW_W'(GLYPH_H - 1)) begin
						rowc_q <= '0;
						col_q  <= col_q + 1'b1;
					end else begin
						rowc_q <= rowc_q + 1'b1;
					end
				end
			end
			if (hold_load) begin
				hold_valid_q <= 1'b1;
			end else if (push_flush) begin
				hold_valid_q <= 1'b0;
			end
			if (push_scan || push_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.origin) begin
				cur_x_q  <= COORD_W'(pos_x);
				line_x_q <= COORD_W'(pos_x);
				cur_y_q  <= COORD_W'(pos_y);
			end else if (cmd.newline) begin
				cur_x_q <= line_x_q;
				cur_y_q <= sat16(nl_sum);
			end else if (cmd.advance) begin
				cur_x_q <= sat16(adv_sum);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = out_x_q;
	assign pixel_y       = out_y_q;
	assign pixel_color   = out_color_q;
	assign is_foreground = out_fg_q;
	assign last          = out_last_q;

endmodule

@@ hw/rtl/bitmap_text_overlay.sv @@
// Bitmap text overlay: character generator that emits clipped pixel writes.
// Load, set origin, newline and undrawable codes act in their accept cycle. A drawn
// character is accepted, its GLYPH_H rows are fetched from the glyph memory, and its
// GLYPH_W * GLYPH_H pixels are scanned at one pixel a cycle unless the output stalls;
// a flush then emits the last held pixel. The first beat is loaded when the second
// visible pixel is scanned. Reset clears cursor, presets config; glyphs are undefined.
module bitmap_text_overlay import bto_pkg::*; #(
	parameter int GLYPH_W    = 8,
	parameter int GLYPH_H    = 8,
	parameter int MAX_GLYPHS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [7:0]            char_code,
	input  logic [ROW_W-1:0]      glyph_row,
	input  logic [7:0]            row_bits,
	input  logic signed [11:0]    pos_x,
	input  logic signed [11:0]    pos_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_x,
	output logic [PIX_W-1:0]      pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  is_foreground,
	output logic                  last
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_count  <= 9'd128;
			cfg_q.kerning      <= 5'sd0;
			cfg_q.image_width  <= 12'd640;
			cfg_q.image_height <= 12'd480;
			cfg_q.fg_color     <= 24'hFFFFFF;
			cfg_q.bg_color     <= 24'h000000;
			cfg_q.bg_enable    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH_COUNT:  cfg_q.glyph_count  <= cfg_data[8:0];
				REG_KERNING:      cfg_q.kerning      <= cfg_data[4:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[11:0];
				REG_FG_COLOR:     cfg_q.fg_color     <= cfg_data;
				REG_BG_COLOR:     cfg_q.bg_color     <= cfg_data;
				REG_BG_ENABLE:    cfg_q.bg_enable    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bto_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	bto_dp #(
		.GLYPH_W    (GLYPH_W),
		.GLYPH_H    (GLYPH_H),
		.MAX_GLYPHS (MAX_GLYPHS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.st            (st),
		.operation     (operation),
		.char_code     (char_code),
		.glyph_row     (glyph_row),
		.row_bits      (row_bits),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.is_foreground (is_foreground),
		.last          (last)
	);

	// No pixel may still be held back when a new item can be taken.
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !st.hold_valid)
		else $error("held pixel pending while accepting input");

	// Draw phases are mutually exclusive.
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.fetch, cmd.scan, cmd.flush}))
		else $error("overlapping draw phases");

	// Starting a draw closes the input until the character is done.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !in_ready)
		else $error("input accepted during draw");

endmodule
